### sv/rgblur_pkg.sv
// ----------------------------------------------------------------------------
// rgblur_pkg
// Shared types, widths and constants for the region gaussian blur.
// ----------------------------------------------------------------------------
package rgblur_pkg;

    localparam int COL_W    = 11;
    localparam int ROW_W    = 11;
    localparam int INROW_W  = 12;
    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int NCH      = 3;
    localparam int WT_W     = 16;
    localparam int MOD_W    = 4;
    localparam int SUM_W    = 28;   // vertical sum of up to 15 rows
    localparam int HPROD_W  = SUM_W + WT_W;
    localparam int ACC_W    = 48;
    localparam int CFG_W    = 22;
    localparam int ADDR_W   = 3;

    localparam logic [INROW_W-1:0] ROW_CAP  = 12'd4095;
    localparam logic [ROW_W-1:0]   MAX_ROWS = 11'd1024;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_IMAGE_COLS   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_IMAGE_ROWS   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COL_RANGE    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ROW_RANGE    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_CENTER_WT    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_WEIGHT_ONE   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_WEIGHT_TWO   = 3'd6;
    localparam logic [ADDR_W-1:0] REG_WEIGHT_THREE = 3'd7;

    localparam logic [WT_W-1:0] RST_W0 = 16'd9381;
    localparam logic [WT_W-1:0] RST_W1 = 16'd9376;
    localparam logic [WT_W-1:0] RST_W2 = 16'd9362;
    localparam logic [WT_W-1:0] RST_W3 = 16'd9339;

    typedef struct packed {
        logic [WT_W-1:0] w3;
        logic [WT_W-1:0] w2;
        logic [WT_W-1:0] w1;
        logic [WT_W-1:0] w0;
    } weights_t;

    // column token walking down the row cells
    typedef struct packed {
        logic                          valid;
        logic                          first;
        logic                          last;
        logic                          center_col;
        logic                          col_ok;
        logic [MOD_W-1:0]              tap_dist;
        logic [COL_W-1:0]              col;
        logic [NCH-1:0][SUM_W-1:0]     sum;
        logic [PIX_W-1:0]              center;
    } tok_t;

    typedef struct packed {
        logic                          done;
        logic [NCH-1:0][ACC_W-1:0]     acc;
        logic [PIX_W-1:0]              center;
    } hacc_res_t;

    function automatic logic [WT_W-1:0] weight_sel(weights_t w, logic [MOD_W-1:0] tap_dist);
        logic [WT_W-1:0] r;
        case (tap_dist)
            4'd0:    r = w.w0;
            4'd1:    r = w.w1;
            4'd2:    r = w.w2;
            4'd3:    r = w.w3;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/rgblur_cell.sv
// ----------------------------------------------------------------------------
// rgblur_cell
// One image row slot: line memory, vertical weight, partial column sum.
// ----------------------------------------------------------------------------
module rgblur_cell #(
    parameter int ROW_IDX  = 0,
    parameter int SPAN     = 7,
    parameter int RADIUS   = 3,
    parameter int MAX_COLS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [rgblur_pkg::COL_W-1:0]    wr_col,
    input  logic [rgblur_pkg::PIX_W-1:0]    wr_pix,
    input  logic [rgblur_pkg::MOD_W-1:0]    rmod,
    input  logic [rgblur_pkg::ROW_W-1:0]    out_row,
    input  logic [rgblur_pkg::ROW_W-1:0]    rows,
    input  rgblur_pkg::weights_t            wts,
    input  rgblur_pkg::tok_t                tok_in,
    output rgblur_pkg::tok_t                tok_out
);
    import rgblur_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam logic [MOD_W-1:0] IDX_M  = MOD_W'(ROW_IDX);
    localparam logic [MOD_W-1:0] SPAN_M = MOD_W'(SPAN);
    localparam logic [MOD_W-1:0] RAD_M  = MOD_W'(RADIUS);

    logic [PIX_W-1:0] mem [MAX_COLS];
    logic [PIX_W-1:0] rd_reg;
    tok_t             tok_a_reg, tok_b_reg;
    logic             va_reg, vb_reg;

    logic [MOD_W:0]   dsum;
    logic [MOD_W-1:0] d, vdist;
    logic             below, row_ok, ok;
    logic [WT_W-1:0]  w;
    tok_t             tok_b_next;

    // row offset of this slot relative to the output row
    always_comb begin
        dsum   = {1'b0, IDX_M} + {1'b0, SPAN_M} - {1'b0, rmod};
        d      = (dsum >= {1'b0, SPAN_M}) ? MOD_W'(dsum - {1'b0, SPAN_M}) : dsum[MOD_W-1:0];
        below  = (d > RAD_M);
        vdist  = below ? (SPAN_M - d) : d;
        row_ok = below ? (out_row >= ROW_W'(vdist))
                       : (({1'b0, out_row} + (ROW_W+1)'(d)) < {1'b0, rows});
        w      = weight_sel(wts, vdist);
        ok     = row_ok && tok_a_reg.col_ok;
    end

    always_comb begin
        tok_b_next = tok_a_reg;
        for (int ch = 0; ch < NCH; ch++) begin
            tok_b_next.sum[ch] = tok_a_reg.sum[ch] + (ok ?
                SUM_W'(w) * SUM_W'(rd_reg[PIX_W-1-CH_W*ch -: CH_W]) : SUM_W'(0));
        end
        if (d == '0 && tok_a_reg.center_col) begin
            tok_b_next.center = ok ? rd_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_col[AW-1:0]] <= wr_pix;
        end
        rd_reg    <= mem[tok_in.col[AW-1:0]];
        tok_a_reg <= tok_in;
        tok_b_reg <= tok_b_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= tok_in.valid;
            vb_reg <= va_reg;
        end
    end

    always_comb begin
        tok_out       = tok_b_reg;
        tok_out.valid = vb_reg;
    end

endmodule

### sv/rgblur_hacc.sv
// ----------------------------------------------------------------------------
// rgblur_hacc
// Horizontal weighting and accumulation of column sums from the cell row.
// ----------------------------------------------------------------------------
module rgblur_hacc (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rgblur_pkg::weights_t   wts,
    input  rgblur_pkg::tok_t       tok,
    output rgblur_pkg::hacc_res_t  res
);
    import rgblur_pkg::*;

    logic [NCH-1:0][HPROD_W-1:0] prod_reg;
    logic [NCH-1:0][ACC_W-1:0]   acc_reg;
    logic                        vp_reg, done_reg;
    logic                        first_reg, last_reg, cc_reg;
    logic [PIX_W-1:0]            cpix_reg, center_reg;
    logic [WT_W-1:0]             w;

    assign w = weight_sel(wts, tok.tap_dist);

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NCH; ch++) begin
            prod_reg[ch] <= tok.sum[ch] * w;
        end
        first_reg <= tok.first;
        last_reg  <= tok.last;
        cc_reg    <= tok.center_col;
        cpix_reg  <= tok.center;
        if (vp_reg) begin
            for (int ch = 0; ch < NCH; ch++) begin
                acc_reg[ch] <= (first_reg ? ACC_W'(0) : acc_reg[ch]) + ACC_W'(prod_reg[ch]);
            end
            if (cc_reg) begin
                center_reg <= cpix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            vp_reg   <= tok.valid;
            done_reg <= vp_reg && last_reg;
        end
    end

    assign res.done   = done_reg;
    assign res.acc    = acc_reg;
    assign res.center = center_reg;

endmodule

### sv/region_gaussian_blur_top.sv
// ----------------------------------------------------------------------------
// region_gaussian_blur_top
// Streaming RGB region blur with a 2*RADIUS+1 square separable gaussian.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one pixel per transfer in raster order, tuser high marks a
//   flush transfer that carries no pixel and only moves the window on.
//   m_ channel: one pixel per transfer, lagged RADIUS rows and RADIUS columns
//   behind the input, tlast on the last pixel of the frame.
//   cfg port: single cycle register writes, only while the block is idle.
// timing:
//   an input transfer that makes no output only passes the position check; one
//   that makes an output also runs the column sweep into the row of cells, the
//   registered step of each cell and the accumulator, and is finished once its
//   pixel enters the output register; no input is taken until then.
// reset: counters, handshakes and configuration registers return to their defaults; the
//   line memories are not cleared, every entry is written before it is read.
// stall: a finished pixel waits in the output register; the next input is
//   taken meanwhile and its pixel waits at the end until the register frees.
// ----------------------------------------------------------------------------
module region_gaussian_blur_top #(
    parameter int RADIUS   = 3,
    parameter int MAX_COLS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        s_tuser,   // flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast,   // frame_last
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [21:0] cfg_wdata
);
    import rgblur_pkg::*;

    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int POS_W = 25;
    localparam logic [MOD_W-1:0] SPAN_M = MOD_W'(SPAN);
    localparam logic [MOD_W-1:0] RAD_M  = MOD_W'(RADIUS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POS   = 5'b00010,
        S_SWEEP = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [COL_W-1:0] image_cols_reg;
    logic [ROW_W-1:0] image_rows_reg;
    logic [CFG_W-1:0] col_range_reg, row_range_reg;
    weights_t         wts_reg;

    // raster counters
    logic [INROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [MOD_W-1:0]   in_mod_reg, in_mod_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [MOD_W-1:0]   rmod_reg, rmod_next;
    logic [MOD_W-1:0]   k_reg, k_next;

    logic [INROW_W+COL_W:0] mul_reg;       // in_row * cols, 24 bits
    logic [COL_W-1:0]       col_save_reg;

    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic              m_tlast_reg;

    logic [COL_W:0]    cols;
    logic [ROW_W-1:0]  rows;
    logic              s_accept, in_ok, emit, last, in_rect, load;
    logic [PIX_W-1:0]  wr_pix, res_pix;
    logic [POS_W-1:0]  pos, lag;
    logic signed [12:0] cc_s;
    hacc_res_t         hres;
    tok_t              chain [SPAN+1];

    // effective image size
    always_comb begin
        if (image_cols_reg == '0) begin
            cols = 12'd1;
        end else if ({1'b0, image_cols_reg} > 12'(MAX_COLS)) begin
            cols = 12'(MAX_COLS);
        end else begin
            cols = {1'b0, image_cols_reg};
        end
        if (image_rows_reg == '0) begin
            rows = 11'd1;
        end else if (image_rows_reg > MAX_ROWS) begin
            rows = MAX_ROWS;
        end else begin
            rows = image_rows_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_ok    = (in_row_reg < {1'b0, rows}) && ({1'b0, in_col_reg} < cols);
    assign wr_pix   = s_tuser ? '0 : {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    // output lags the input by RADIUS rows and RADIUS columns
    assign pos  = POS_W'(mul_reg) + POS_W'(col_save_reg);
    assign lag  = POS_W'(cols) * POS_W'(RADIUS) + POS_W'(RADIUS);
    assign emit = (pos >= lag);

    // column token fed into the first cell during the sweep
    assign cc_s = signed'({2'b00, out_col_reg}) + signed'({9'd0, k_reg}) - 13'(RADIUS);

    always_comb begin
        chain[0]            = '0;
        chain[0].valid      = (state_reg == S_SWEEP);
        chain[0].first      = (k_reg == '0);
        chain[0].last       = (k_reg == SPAN_M - 1'b1);
        chain[0].center_col = (k_reg == RAD_M);
        chain[0].col_ok     = !cc_s[12] && (cc_s[11:0] < cols);
        chain[0].tap_dist   = (k_reg <= RAD_M) ? (RAD_M - k_reg) : (k_reg - RAD_M);
        chain[0].col        = cc_s[COL_W-1:0];
    end

    // row of cells, one per line slot
    for (genvar b = 0; b < SPAN; b++) begin : g_cell
        rgblur_cell #(
            .ROW_IDX  (b),
            .SPAN     (SPAN),
            .RADIUS   (RADIUS),
            .MAX_COLS (MAX_COLS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (s_accept && in_ok && (in_mod_reg == MOD_W'(b))),
            .wr_col  (in_col_reg),
            .wr_pix  (wr_pix),
            .rmod    (rmod_reg),
            .out_row (out_row_reg),
            .rows    (rows),
            .wts     (wts_reg),
            .tok_in  (chain[b]),
            .tok_out (chain[b+1])
        );
    end

    rgblur_hacc u_hacc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wts     (wts_reg),
        .tok     (chain[SPAN]),
        .res     (hres)
    );

    // result selection: blurred inside the rectangle, center pixel elsewhere
    assign last    = (({1'b0, out_row_reg} + 12'd1) >= {1'b0, rows}) &&
                     (({1'b0, out_col_reg} + 12'd1) >= cols);
    assign in_rect = (out_row_reg >= row_range_reg[10:0]) && (out_row_reg < row_range_reg[21:11]) &&
                     (out_col_reg >= col_range_reg[10:0]) && (out_col_reg < col_range_reg[21:11]);

    always_comb begin
        res_pix = hres.center;
        if (in_rect) begin
            for (int ch = 0; ch < NCH; ch++) begin
                res_pix[PIX_W-1-CH_W*ch -: CH_W] = (hres.acc[ch][ACC_W-1:40] != '0) ?
                    8'hFF : hres.acc[ch][39:32];
            end
        end
    end

    assign load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // sequencing and counters
    always_comb begin
        state_next   = state_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_mod_next  = in_mod_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        rmod_next    = rmod_reg;
        k_next       = k_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_POS;
                    if (({1'b0, in_col_reg} + 12'd1) >= cols) begin
                        in_col_next = '0;
                        if (in_row_reg < ROW_CAP) begin
                            in_row_next = in_row_reg + 1'b1;
                            in_mod_next = (in_mod_reg == SPAN_M - 1'b1) ? '0 : in_mod_reg + 1'b1;
                        end
                    end else begin
                        in_col_next = in_col_reg + 1'b1;
                    end
                end
            end
            S_POS: begin
                k_next     = '0;
                state_next = emit ? S_SWEEP : S_IDLE;
            end
            S_SWEEP: begin
                k_next = k_reg + 1'b1;
                if (k_reg == SPAN_M - 1'b1) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (hres.done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    state_next = S_IDLE;
                    if (last) begin
                        in_row_next  = '0;
                        in_col_next  = '0;
                        in_mod_next  = '0;
                        out_row_next = '0;
                        out_col_next = '0;
                        rmod_next    = '0;
                    end else if (({1'b0, out_col_reg} + 12'd1) >= cols) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                        rmod_next    = (rmod_reg == SPAN_M - 1'b1) ? '0 : rmod_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_mod_reg     <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            rmod_reg       <= '0;
            k_reg          <= '0;
            m_tvalid_reg   <= 1'b0;
            image_cols_reg <= 11'd1024;
            image_rows_reg <= 11'd1024;
            col_range_reg  <= '0;
            row_range_reg  <= '0;
            wts_reg        <= '{w3: RST_W3, w2: RST_W2, w1: RST_W1, w0: RST_W0};
        end else begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            in_mod_reg  <= in_mod_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            rmod_reg    <= rmod_next;
            k_reg       <= k_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_IMAGE_COLS:   image_cols_reg <= cfg_wdata[COL_W-1:0];
                    REG_IMAGE_ROWS:   image_rows_reg <= cfg_wdata[ROW_W-1:0];
                    REG_COL_RANGE:    col_range_reg  <= cfg_wdata;
                    REG_ROW_RANGE:    row_range_reg  <= cfg_wdata;
                    REG_CENTER_WT:    wts_reg.w0     <= cfg_wdata[WT_W-1:0];
                    REG_WEIGHT_ONE:   wts_reg.w1     <= cfg_wdata[WT_W-1:0];
                    REG_WEIGHT_TWO:   wts_reg.w2     <= cfg_wdata[WT_W-1:0];
                    REG_WEIGHT_THREE: wts_reg.w3     <= cfg_wdata[WT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mul_reg      <= in_row_reg * cols;
            col_save_reg <= in_col_reg;
        end
        if (load) begin
            m_tdata_reg <= {res_pix[7:0], res_pix[15:8], res_pix[23:16]};
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // the accumulator finishes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        hres.done |-> state_reg == S_WAIT)
        else $error("accumulator finished outside the wait state");

    // a new output transfer is only ever staged from the done state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg == S_DONE))
        else $error("output register loaded outside the done state");

    // line slot pointers stay inside the row of cells
    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_mod_reg < SPAN_M) && (rmod_reg < SPAN_M))
        else $error("line slot pointer out of range");
`endif

endmodule

### sim/region_gaussian_blur_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_gaussian_blur_top_tb
// Self-checking bench for the streaming RGB region blur. A few hand-checked
// 1x1 frames come first, then random frames on small images, mostly under
// random sizes, rectangles and weights; the phases cycle four idle patterns.
// Every output pixel is checked by hand or against a software blur of the stream.
// ----------------------------------------------------------------------------
module region_gaussian_blur_top_tb;
    import rgblur_pkg::*;

    localparam int RAD        = 3;
    localparam int SPAN       = 2 * RAD + 1;
    localparam int MAXC       = 1024;
    localparam int ITEM_GOAL  = 1900;
    localparam int DRAIN_WAIT = 40;
    localparam int HOLD_LEN   = 300;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct {
        logic [23:0] px;
        logic        last;
    } pix_out_t;

    // one row of the hand-written table; want is typed only where obvious
    typedef struct {
        logic        flush;
        logic [23:0] px;
        logic        typed;
        logic [23:0] want;
        logic        want_last;
        logic        blur_cfg;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [21:0] cfg_wdata = '0;

    region_gaussian_blur_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // red, green, blue
        .s_tuser(s_tuser),   // flush
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // out_red, out_green, out_blue
        .m_tlast(m_tlast),   // frame_last
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // 20 ns period
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // mirror of the register file
    logic [10:0] img_cols_r, img_rows_r;
    logic [21:0] col_rng_r, row_rng_r;
    logic [15:0] wt0_r, wt1_r, wt2_r, wt3_r;

    // software copy of the line memories and raster counters
    logic [23:0] pix_store [SPAN][MAXC];
    int unsigned in_r, in_c, out_r, out_c;

    pix_out_t    blur_out_q[$];
    int          err_cnt = 0;
    int          items_sent = 0;
    int          src_pct = 0;
    int          dst_pct = 0;
    int          hold_left = 0;
    int          cycles = 0;

    function automatic logic [15:0] tap_wt(input int d);
        if (d < 0) d = -d;
        case (d)
            0: return wt0_r;
            1: return wt1_r;
            2: return wt2_r;
            3: return wt3_r;
            default: return 16'd0;
        endcase
    endfunction

    function automatic int unsigned eff_cols();
        if (img_cols_r < 1) return 1;
        if (img_cols_r > MAXC) return MAXC;
        return img_cols_r;
    endfunction

    function automatic int unsigned eff_rows();
        if (img_rows_r < 1) return 1;
        if (img_rows_r > 1024) return 1024;
        return img_rows_r;
    endfunction

    // advance the raster by one transfer; returns 1 when a pixel comes out
    function automatic logic blur_step(input logic fl, input logic [23:0] px,
                                       output pix_out_t res);
        int unsigned cols, rows, pos, lag, x1, x2, y1, y2;
        int          rr, cc;
        longint unsigned acc;
        logic [23:0] val;
        cols = eff_cols();
        rows = eff_rows();
        res.px = '0;
        res.last = 1'b0;
        if (in_r < rows && in_c < cols)
            pix_store[in_r % SPAN][in_c] = fl ? 24'd0 : px;
        pos = in_r * cols + in_c;
        lag = RAD * cols + RAD;
        in_c++;
        if (in_c >= cols) begin
            in_c = 0;
            if (in_r < 4095) in_r++;
        end
        if (pos < lag) return 1'b0;
        x1 = col_rng_r[10:0];
        x2 = col_rng_r[21:11];
        y1 = row_rng_r[10:0];
        y2 = row_rng_r[21:11];
        val = (out_r < rows && out_c < cols) ? pix_store[out_r % SPAN][out_c] : 24'd0;
        if (out_r >= y1 && out_r < y2 && out_c >= x1 && out_c < x2) begin
            for (int ch = 0; ch < 3; ch++) begin
                acc = 0;
                for (int dr = -RAD; dr <= RAD; dr++) begin
                    rr = int'(out_r) + dr;
                    if (rr < 0 || rr >= int'(rows)) continue;
                    for (int dc = -RAD; dc <= RAD; dc++) begin
                        cc = int'(out_c) + dc;
                        if (cc < 0 || cc >= int'(cols)) continue;
                        acc += longint'(tap_wt(dr)) * longint'(tap_wt(dc)) *
                               longint'(pix_store[rr % SPAN][cc][16 - 8 * ch +: 8]);
                    end
                end
                acc = acc >> 32;
                if (acc > 255) acc = 255;
                val[16 - 8 * ch +: 8] = acc[7:0];
            end
        end
        res.px = val;
        res.last = (out_r + 1 >= rows) && (out_c + 1 >= cols);
        if (res.last) begin
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
        end else begin
            out_c++;
            if (out_c >= cols) begin
                out_c = 0;
                out_r++;
            end
        end
        return 1'b1;
    endfunction

    task automatic report(input string fld, input int got, input int want);
        $display("mismatch %s: got %0h want %0h (t=%0t)", fld, got, want, $time);
        err_cnt++;
    endtask

    // output side: compare every transfer with the oldest expected pixel
    // bus order is red in the low byte, the software pixel keeps red on top
    always @(posedge aclk) begin
        pix_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (blur_out_q.size() == 0) begin
                report("unexpected pixel", m_tdata, 0);
            end else begin
                e = blur_out_q.pop_front();
                if (m_tdata[7:0] !== e.px[23:16]) report("red", m_tdata[7:0], e.px[23:16]);
                if (m_tdata[15:8] !== e.px[15:8]) report("green", m_tdata[15:8], e.px[15:8]);
                if (m_tdata[23:16] !== e.px[7:0]) report("blue", m_tdata[23:16], e.px[7:0]);
                if (m_tlast !== e.last) report("tlast", m_tlast, e.last);
            end
        end
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (aresetn) begin
            m_tready <= ($urandom_range(0, 99) >= dst_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("region_gaussian_blur_top regression: fail");
            $finish;
        end
    end

    // one register write per call; caller lowers the enable afterwards
    task automatic cfg_one(input logic [2:0] idx, input logic [21:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic cfg_load(input logic [10:0] cols, input logic [10:0] rows,
                            input logic [21:0] crng, input logic [21:0] rrng,
                            input logic [15:0] w0, input logic [15:0] w1,
                            input logic [15:0] w2, input logic [15:0] w3);
        cfg_one(REG_IMAGE_COLS, 22'(cols));
        cfg_one(REG_IMAGE_ROWS, 22'(rows));
        cfg_one(REG_COL_RANGE, crng);
        cfg_one(REG_ROW_RANGE, rrng);
        cfg_one(REG_CENTER_WT, 22'(w0));
        cfg_one(REG_WEIGHT_ONE, 22'(w1));
        cfg_one(REG_WEIGHT_TWO, 22'(w2));
        cfg_one(REG_WEIGHT_THREE, 22'(w3));
        cfg_wr_en <= 1'b0;
        img_cols_r = cols;
        img_rows_r = rows;
        col_rng_r = crng;
        row_rng_r = rrng;
        wt0_r = w0;
        wt1_r = w1;
        wt2_r = w2;
        wt3_r = w3;
        @(negedge aclk);
    endtask

    // block idle: all pixels out, then room for a trailing non-emitting transfer
    task automatic wait_drained();
        while (blur_out_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // one input transfer; entered and left at a falling edge, tvalid left high
    task automatic send_px(input logic fl, input logic [23:0] px,
                           input logic typed, input pix_out_t want);
        pix_out_t r;
        while ($urandom_range(0, 99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fl;
        s_tdata <= {px[7:0], px[15:8], px[23:16]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (blur_step(fl, px, r)) blur_out_q.push_back(typed ? want : r);
        items_sent++;
        @(negedge aclk);
    endtask

    // full frame of random pixels plus the drain; pixels in the drain are dropped
    task automatic send_frame(input logic pressure);
        int unsigned n, lag;
        pix_out_t none;
        none.px = '0;
        none.last = 1'b0;
        n = eff_cols() * eff_rows();
        lag = RAD * eff_cols() + RAD;
        for (int unsigned i = 0; i < n; i++) begin
            if (pressure && i == n / 4) begin
                // sender pause until the pipe is empty
                s_tvalid <= 1'b0;
                while (blur_out_q.size() != 0) @(negedge aclk);
            end
            if (pressure && i == n / 2) hold_left = HOLD_LEN;
            send_px($urandom_range(0, 15) == 0, 24'($urandom), 1'b0, none);
        end
        for (int unsigned i = 0; i < lag; i++)
            send_px($urandom_range(0, 7) != 0, 24'($urandom), 1'b0, none);
    endtask

    function automatic logic [21:0] rand_range();
        logic [10:0] lo, hi;
        if ($urandom_range(0, 7) == 0) return 22'($urandom);
        lo = 11'($urandom_range(0, 9));
        hi = 11'($urandom_range(0, 12));
        return {hi, lo};
    endfunction

    function automatic logic [15:0] rand_wt();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    dir_row_t dir_tbl[21];

    initial begin
        pix_out_t tw;
        int ph;
        int mode;
        // 1x1 frames: passthrough, flush pixel with a dropped drain pixel,
        // then a full-weight blur that floors just below saturation
        dir_tbl = '{
            '{0, 24'hFFFFFF, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 1, 24'hFFFFFF, 1, 0},
            '{1, 24'hFFFFFF, 0, 24'h0, 0, 0}, '{0, 24'hABCDEF, 0, 24'h0, 0, 0},
            '{1, 24'h0, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 1, 24'h000000, 1, 0},
            '{0, 24'hFFFFFF, 0, 24'h0, 0, 1}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 0, 24'h0, 0, 0}, '{1, 24'h0, 0, 24'h0, 0, 0},
            '{1, 24'h0, 1, 24'hFEFEFE, 1, 0}
        };
        for (int r = 0; r < SPAN; r++)
            for (int c = 0; c < MAXC; c++) pix_store[r][c] = '0;
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;

        // reset held low, then released at a falling edge
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        cfg_load(11'd1, 11'd1, 22'd0, 22'd0, RST_W0, RST_W1, RST_W2, RST_W3);
        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].blur_cfg) begin
                s_tvalid <= 1'b0;
                wait_drained();
                cfg_load(11'd1, 11'd1, {11'd1, 11'd0}, {11'd1, 11'd0},
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end
            tw.px = dir_tbl[i].want;
            tw.last = dir_tbl[i].want_last;
            send_px(dir_tbl[i].flush, dir_tbl[i].px, dir_tbl[i].typed, tw);
        end

        // random phases, cycling through the idle patterns
        ph = 0;
        while (items_sent < ITEM_GOAL) begin
            mode = ph % 4;
            src_pct = (mode == 1) ? 51 : (mode == 3) ? 33 : 0;
            dst_pct = (mode == 2) ? 51 : (mode == 3) ? 33 : 0;
            s_tvalid <= 1'b0;
            wait_drained();
            case (ph)
                0: cfg_load(11'd0, 11'd0, 22'h3FFFFF, 22'h3FFFFF, 16'h0, 16'h0, 16'h0,
                            16'h0);
                1: cfg_load(11'd12, 11'd9, {11'd2047, 11'd0}, {11'd2047, 11'd0},
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: cfg_load(11'd9, 11'd8, {11'd9, 11'd0}, {11'd8, 11'd0},
                            RST_W0, RST_W1, RST_W2, RST_W3);
                default: cfg_load(11'($urandom_range(0, 10)), 11'($urandom_range(0, 9)),
                                  rand_range(), rand_range(),
                                  rand_wt(), rand_wt(), rand_wt(), rand_wt());
            endcase
            for (int f = 0; f < 3; f++) send_frame(ph == 4 && f == 1);
            ph++;
        end
        s_tvalid <= 1'b0;

        // wait for the last pixels, then let the pipe settle
        while (blur_out_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (err_cnt == 0 && blur_out_q.size() == 0) begin
            $display("region_gaussian_blur_top regression: pass");
        end else begin
            $display("region_gaussian_blur_top regression: fail");
        end
        $finish;
    end

endmodule

### region_gaussian_blur_top.f
sv/rgblur_pkg.sv
sv/rgblur_cell.sv
sv/rgblur_hacc.sv
sv/region_gaussian_blur_top.sv
sim/region_gaussian_blur_top_tb.sv
